/* hdl/stk_pkg.sv */
// ----------------------------------------------------------------------------
// stk_pkg: shared types and constants for the STK500v1 upload sequencer
// Opcode bytes, reply bytes, operation and status codes, register indexes,
// register reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package stk_pkg;

	// default geometry
	localparam int PAGE_BYTES_DEF      = 128;
	localparam int MAX_IMAGE_BYTES_DEF = 65536;

	// item field widths
	localparam int OP_W    = 2;
	localparam int SIZE_W  = 17;
	localparam int BYTE_W  = 8;
	localparam int ADDR_W  = 16;
	localparam int STAT_W  = 3;
	localparam int PIDX_W  = 8;
	localparam int ATT_W   = 7;
	localparam int TMR_W   = 12;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	// register reset values
	localparam logic [7:0]  QUIET_RST     = 8'd5;
	localparam logic [9:0]  SYNC_WAIT_RST = 10'd80;
	localparam logic [11:0] REPLY_WAIT_RST = 12'd1000;
	localparam logic [7:0]  GAP_RST       = 8'd10;
	localparam logic [6:0]  ATTEMPTS_RST  = 7'd64;

	// protocol bytes
	localparam logic [7:0] CMD_GET_SYNC   = 8'h30;
	localparam logic [7:0] CMD_ENTER_PROG = 8'h50;
	localparam logic [7:0] CMD_LEAVE_PROG = 8'h51;
	localparam logic [7:0] CMD_LOAD_ADDR  = 8'h55;
	localparam logic [7:0] CMD_PROG_PAGE  = 8'h64;
	localparam logic [7:0] MEM_FLASH      = 8'h46;
	localparam logic [7:0] SYNC_EOP       = 8'h20;
	localparam logic [7:0] RESP_INSYNC    = 8'h14;
	localparam logic [7:0] RESP_OK        = 8'h10;
	localparam logic [7:0] PAD_BYTE       = 8'hFF;

	localparam logic [TMR_W-1:0] TMR_MAX = '1;
	localparam logic [ATT_W-1:0] ATT_MAX = '1;

	typedef enum logic [OP_W-1:0] {
		OP_START = 2'd0,
		OP_RX    = 2'd1,
		OP_TICK  = 2'd2,
		OP_SLOT  = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_IDLE     = 3'd0,
		ST_BUSY     = 3'd1,
		ST_DONE     = 3'd2,
		ST_SYNC_ERR = 3'd3,
		ST_CMD_ERR  = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_QUIET      = 3'd0,
		CFG_SYNC_WAIT  = 3'd1,
		CFG_REPLY_WAIT = 3'd2,
		CFG_GAP        = 3'd3,
		CFG_ATTEMPTS   = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0]  quiet_ticks;
		logic [9:0]  sync_wait_ticks;
		logic [11:0] reply_wait_ticks;
		logic [7:0]  retry_gap_ticks;
		logic [6:0]  sync_attempts;
	} cfg_t;

endpackage

/* hdl/stk_in_if.sv */
// ----------------------------------------------------------------------------
// stk_in_if: input event channel
// One beat is a start, received byte, tick or transmit slot event.
// ----------------------------------------------------------------------------
interface stk_in_if
	import stk_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [SIZE_W-1:0] image_size;
	logic [BYTE_W-1:0] rx_byte;
	logic [BYTE_W-1:0] image_byte;

	modport source (output valid, operation, image_size, rx_byte, image_byte,
		input ready);
	modport sink (input valid, operation, image_size, rx_byte, image_byte,
		output ready);
endinterface

/* hdl/stk_out_if.sv */
// ----------------------------------------------------------------------------
// stk_out_if: result channel
// One beat per input event: transmit byte, fetch address and status.
// ----------------------------------------------------------------------------
interface stk_out_if
	import stk_pkg::*;
;
	logic              valid;
	logic              ready;
	logic              tx_valid;
	logic [BYTE_W-1:0] tx_byte;
	logic [ADDR_W-1:0] fetch_address;
	logic [STAT_W-1:0] status;

	modport source (output valid, tx_valid, tx_byte, fetch_address, status,
		input ready);
	modport sink (input valid, tx_valid, tx_byte, fetch_address, status,
		output ready);
endinterface

/* hdl/stk500_flash_upload_sequencer.sv */
// ----------------------------------------------------------------------------
// stk500_flash_upload_sequencer: STK500v1 host-side flash upload
// Flush, sync with retries, program mode, paged flash writes, leave mode.
// ----------------------------------------------------------------------------
// The result of an event is registered and presented in the cycle after its beat.
// Throughput: one event per cycle while the result side is ready; the
// next-state logic is a single pass from the sequencer registers into
// the state and result registers. Only a held, untaken result blocks input.
// Reset: idle phase, counters cleared, registers at defaults, no result.
module stk500_flash_upload_sequencer
	import stk_pkg::*;
#(
	parameter int PAGE_BYTES      = PAGE_BYTES_DEF,
	parameter int MAX_IMAGE_BYTES = MAX_IMAGE_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	stk_in_if.sink                in_ch,
	stk_out_if.source             out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [4:0] {
		PH_IDLE, PH_FLUSH, PH_SYNC_TX, PH_SYNC_WAIT, PH_GAP, PH_ENTER_TX,
		PH_ENTER_WAIT, PH_LOAD_TX, PH_LOAD_WAIT, PH_HDR_TX, PH_DATA_TX,
		PH_EOP_TX, PH_PAGE_WAIT, PH_LEAVE_TX, PH_LEAVE_WAIT, PH_DONE,
		PH_FAIL_SYNC, PH_FAIL_CMD
	} phase_t;

	localparam logic [PIDX_W:0]   PAGE_LEN = (PIDX_W+1)'(PAGE_BYTES);
	localparam logic [7:0]        PAGE_HI  = 8'(PAGE_BYTES >> 8);
	localparam logic [7:0]        PAGE_LO  = 8'(PAGE_BYTES & 255);
	localparam logic [SIZE_W:0]   MAX_LEN  = (SIZE_W+1)'(MAX_IMAGE_BYTES);
	localparam logic [SIZE_W:0]   PAGE_INC = (SIZE_W+1)'(PAGE_BYTES);

	cfg_t cfg;

	stk_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// sequencer state
	phase_t              phase_q, phase_d;
	logic [PIDX_W-1:0]   pidx_q, pidx_d;
	logic [SIZE_W-1:0]   page_q, page_d;
	logic [SIZE_W-1:0]   len_q, len_d;
	logic [ATT_W-1:0]    att_q, att_d;
	logic [TMR_W-1:0]    tmr_q, tmr_d;
	logic                ins_q, ins_d;

	// result register
	logic                out_valid_q;
	logic                tx_valid_q;
	logic [BYTE_W-1:0]   tx_byte_q;
	logic [ADDR_W-1:0]   fetch_q;
	status_t             status_q;

	logic                accept;
	logic                txv;
	logic [BYTE_W-1:0]   txb;
	logic [ADDR_W-1:0]   fetch_d;
	status_t             status_d;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	// next state and result for one event
	always_comb begin
		logic               go_en;
		phase_t             go_ph;
		logic               fw_en;
		logic               fw_ok;
		logic               waiting;
		logic [TMR_W-1:0]   tmr_inc;
		logic [TMR_W-1:0]   limit;
		logic [ATT_W-1:0]   att_inc;
		logic [ATT_W-1:0]   att_lim;
		logic [SIZE_W:0]    page_sum;
		logic [SIZE_W:0]    data_pos;
		logic [PIDX_W:0]    pidx_nxt;
		logic [SIZE_W-1:0]  word;

		phase_d  = phase_q;
		pidx_d   = pidx_q;
		page_d   = page_q;
		len_d    = len_q;
		att_d    = att_q;
		tmr_d    = tmr_q;
		ins_d    = ins_q;
		txv      = 1'b0;
		txb      = '0;
		go_en    = 1'b0;
		go_ph    = phase_q;
		fw_en    = 1'b0;
		fw_ok    = 1'b0;
		waiting  = phase_q inside {PH_SYNC_WAIT, PH_ENTER_WAIT, PH_LOAD_WAIT,
			PH_PAGE_WAIT, PH_LEAVE_WAIT};
		tmr_inc  = (tmr_q == TMR_MAX) ? tmr_q : tmr_q + 1'b1;
		limit    = (phase_q == PH_SYNC_WAIT) ? {2'b00, cfg.sync_wait_ticks}
			: cfg.reply_wait_ticks;
		att_inc  = (att_q == ATT_MAX) ? att_q : att_q + 1'b1;
		att_lim  = (cfg.sync_attempts == '0) ? ATT_W'(1) : cfg.sync_attempts;
		page_sum = {1'b0, page_q} + PAGE_INC;
		data_pos = {1'b0, page_q} + {{(SIZE_W+1-PIDX_W){1'b0}}, pidx_q};
		pidx_nxt = {1'b0, pidx_q} + 1'b1;
		word     = {1'b0, page_q[SIZE_W-1:1]};

		case (op_t'(in_ch.operation))
			OP_START: begin
				if (phase_q inside {PH_IDLE, PH_DONE, PH_FAIL_SYNC, PH_FAIL_CMD}) begin
					len_d = ({1'b0, in_ch.image_size} > MAX_LEN) ? MAX_LEN[SIZE_W-1:0]
						: in_ch.image_size;
					page_d = '0;
					att_d  = '0;
					go_en  = 1'b1;
					go_ph  = PH_FLUSH;
				end
			end
			OP_RX: begin
				if (phase_q == PH_FLUSH) begin
					tmr_d = '0;
				end else if (waiting) begin
					if (!ins_q) begin
						if (in_ch.rx_byte == RESP_INSYNC) begin
							ins_d = 1'b1;
							tmr_d = '0;
						end else begin
							fw_en = 1'b1;
						end
					end else begin
						fw_en = 1'b1;
						fw_ok = (in_ch.rx_byte == RESP_OK);
					end
				end
			end
			OP_TICK: begin
				if (phase_q == PH_FLUSH) begin
					tmr_d = tmr_inc;
					if (tmr_inc >= {4'd0, cfg.quiet_ticks}) begin
						go_en = 1'b1;
						go_ph = PH_SYNC_TX;
					end
				end else if (phase_q == PH_GAP) begin
					tmr_d = tmr_inc;
					if (tmr_inc >= {4'd0, cfg.retry_gap_ticks}) begin
						go_en = 1'b1;
						go_ph = (att_q >= att_lim) ? PH_FAIL_SYNC : PH_FLUSH;
					end
				end else if (waiting) begin
					tmr_d = tmr_inc;
					if (tmr_inc >= limit) fw_en = 1'b1;
				end
			end
			OP_SLOT: begin
				txv = 1'b1;
				case (phase_q)
					PH_SYNC_TX, PH_ENTER_TX, PH_LEAVE_TX: begin
						if (pidx_q == '0) begin
							txb = (phase_q == PH_SYNC_TX) ? CMD_GET_SYNC
								: (phase_q == PH_ENTER_TX) ? CMD_ENTER_PROG : CMD_LEAVE_PROG;
							pidx_d = PIDX_W'(1);
						end else begin
							txb   = SYNC_EOP;
							go_en = 1'b1;
							go_ph = (phase_q == PH_SYNC_TX) ? PH_SYNC_WAIT
								: (phase_q == PH_ENTER_TX) ? PH_ENTER_WAIT : PH_LEAVE_WAIT;
						end
					end
					PH_LOAD_TX: begin
						pidx_d = pidx_nxt[PIDX_W-1:0];
						case (pidx_q)
							PIDX_W'(0): txb = CMD_LOAD_ADDR;
							PIDX_W'(1): txb = word[7:0];
							PIDX_W'(2): txb = word[15:8];
							default: begin
								txb   = SYNC_EOP;
								go_en = 1'b1;
								go_ph = PH_LOAD_WAIT;
							end
						endcase
					end
					PH_HDR_TX: begin
						pidx_d = pidx_nxt[PIDX_W-1:0];
						case (pidx_q)
							PIDX_W'(0): txb = CMD_PROG_PAGE;
							PIDX_W'(1): txb = PAGE_HI;
							PIDX_W'(2): txb = PAGE_LO;
							default: begin
								txb   = MEM_FLASH;
								go_en = 1'b1;
								go_ph = PH_DATA_TX;
							end
						endcase
					end
					PH_DATA_TX: begin
						txb = (data_pos < {1'b0, len_q}) ? in_ch.image_byte : PAD_BYTE;
						if (pidx_nxt >= PAGE_LEN) begin
							go_en = 1'b1;
							go_ph = PH_EOP_TX;
						end else begin
							pidx_d = pidx_nxt[PIDX_W-1:0];
						end
					end
					PH_EOP_TX: begin
						txb   = SYNC_EOP;
						go_en = 1'b1;
						go_ph = PH_PAGE_WAIT;
					end
					default: txv = 1'b0;
				endcase
			end
			default: ;
		endcase

		// end of a reply wait
		if (fw_en) begin
			go_en = 1'b1;
			case (phase_q)
				PH_SYNC_WAIT: begin
					if (fw_ok) begin
						go_ph = PH_ENTER_TX;
					end else begin
						att_d = att_inc;
						if (cfg.retry_gap_ticks == '0)
							go_ph = (att_inc >= att_lim) ? PH_FAIL_SYNC : PH_FLUSH;
						else
							go_ph = PH_GAP;
					end
				end
				PH_ENTER_WAIT: go_ph = fw_ok ? PH_LOAD_TX : PH_FAIL_CMD;
				PH_LOAD_WAIT:  go_ph = fw_ok ? PH_HDR_TX : PH_FAIL_CMD;
				PH_PAGE_WAIT: begin
					if (!fw_ok) begin
						go_ph = PH_FAIL_CMD;
					end else begin
						page_d = page_sum[SIZE_W-1:0];
						go_ph  = (page_sum >= {1'b0, len_q}) ? PH_LEAVE_TX : PH_LOAD_TX;
					end
				end
				default: go_ph = PH_DONE;
			endcase
		end

		if (go_en) begin
			phase_d = go_ph;
			pidx_d  = '0;
			tmr_d   = '0;
			ins_d   = 1'b0;
		end

		// result fields from the updated state
		case (phase_d)
			PH_IDLE:      status_d = ST_IDLE;
			PH_DONE:      status_d = ST_DONE;
			PH_FAIL_SYNC: status_d = ST_SYNC_ERR;
			PH_FAIL_CMD:  status_d = ST_CMD_ERR;
			default:      status_d = ST_BUSY;
		endcase
		fetch_d = page_d[ADDR_W-1:0]
			+ ((phase_d == PH_DATA_TX) ? {{(ADDR_W-PIDX_W){1'b0}}, pidx_d} : '0);
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pidx_q  <= '0;
			page_q  <= '0;
			len_q   <= '0;
			att_q   <= '0;
			tmr_q   <= '0;
			ins_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			pidx_q  <= pidx_d;
			page_q  <= page_d;
			len_q   <= len_d;
			att_q   <= att_d;
			tmr_q   <= tmr_d;
			ins_q   <= ins_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tx_valid_q <= txv;
			tx_byte_q  <= txb;
			fetch_q    <= fetch_d;
			status_q   <= status_d;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.tx_valid      = tx_valid_q;
	assign out_ch.tx_byte       = tx_byte_q;
	assign out_ch.fetch_address = fetch_q;
	assign out_ch.status        = status_q;

	// every accepted event yields a result beat
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_ch.valid)
		else $error("no result after accepted event");

	// data index stays inside the page
	a_pidx_in_page: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA_TX |-> {1'b0, pidx_q} < PAGE_LEN)
		else $error("page data index out of range");

	// sync failure only after at least one attempt
	a_fail_attempts: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FAIL_SYNC |-> att_q != '0)
		else $error("sync failure without attempts");

	// wait timer is clear while sending a packet
	a_tmr_clear_tx: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SYNC_TX || phase_q == PH_ENTER_TX || phase_q == PH_LOAD_TX ||
		 phase_q == PH_HDR_TX || phase_q == PH_DATA_TX || phase_q == PH_EOP_TX ||
		 phase_q == PH_LEAVE_TX) |-> tmr_q == '0)
		else $error("wait timer running during transmit");

endmodule

/* hdl/stk_cfg.sv */
// ----------------------------------------------------------------------------
// stk_cfg: configuration register bank
// Write-only timing and retry registers; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module stk_cfg
	import stk_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  we,
	input  logic [CFG_IDX_W-1:0]  index,
	input  logic [CFG_DATA_W-1:0] data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.quiet_ticks      <= QUIET_RST;
			cfg_q.sync_wait_ticks  <= SYNC_WAIT_RST;
			cfg_q.reply_wait_ticks <= REPLY_WAIT_RST;
			cfg_q.retry_gap_ticks  <= GAP_RST;
			cfg_q.sync_attempts    <= ATTEMPTS_RST;
		end else if (we) begin
			case (cfg_idx_t'(index))
				CFG_QUIET:      cfg_q.quiet_ticks      <= data[7:0];
				CFG_SYNC_WAIT:  cfg_q.sync_wait_ticks  <= data[9:0];
				CFG_REPLY_WAIT: cfg_q.reply_wait_ticks <= data[11:0];
				CFG_GAP:        cfg_q.retry_gap_ticks  <= data[7:0];
				CFG_ATTEMPTS:   cfg_q.sync_attempts    <= data[6:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
